[src/ptq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package ptq_pkg;

  // Default table size and the most timers fired by one update.
  localparam int NUM_TIMERS_DEF = 16;
  localparam int RESULT_CAP     = 16;

  // Width of a position in the order list command (enough for 256 entries).
  localparam int ORD_PW = 8;

  // Widths of the stored timer fields.
  localparam int PERIOD_W = 31;
  localparam int TIME_W   = 32;
  localparam int TAG_W    = 32;
  localparam int ENTRY_W  = TIME_W + TAG_W + PERIOD_W;

  typedef enum logic [1:0] {
    KIND_UPDATE   = 2'd0,
    KIND_REGISTER = 2'd1,
    KIND_REMOVE   = 2'd2,
    KIND_BAD      = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    EV_FIRED      = 2'd0,
    EV_REGISTERED = 2'd1,
    EV_REMOVED    = 2'd2,
    EV_REJECTED   = 2'd3
  } event_t;

  typedef enum logic [1:0] {
    ORD_NOP,
    ORD_INSERT,
    ORD_DELETE
  } ord_op_t;

  // Command from the sequencer to the order list.
  typedef struct packed {
    ord_op_t           op;
    logic [ORD_PW-1:0] pos;
  } ord_cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FREE,
    S_LINK_RD,
    S_LINK_DL,
    S_LINK_CMP,
    S_LINK_INS,
    S_RM_FIND,
    S_RM_RD,
    S_UP_RD,
    S_UP_CHK,
    S_UP_POP,
    S_UP_WR,
    S_EMIT
  } state_t;

endpackage
`default_nettype wire

[src/ptq_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
module ptq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[src/ptq_order.sv]
`timescale 1ns / 1ps
`default_nettype none
module ptq_order #(
  parameter int NUM_TIMERS = ptq_pkg::NUM_TIMERS_DEF
) (
  input  wire logic                          clk,
  input  wire ptq_pkg::ord_cmd_t             cmd,
  input  wire logic [$clog2(NUM_TIMERS)-1:0] wr_slot,
  input  wire logic [$clog2(NUM_TIMERS)-1:0] rd_idx,
  output logic      [$clog2(NUM_TIMERS)-1:0] rd_slot
);

  localparam int IW = $clog2(NUM_TIMERS);

  logic [IW-1:0] ord [NUM_TIMERS];
  logic [IW-1:0] pos;

  assign pos     = IW'(cmd.pos);
  assign rd_slot = ord[rd_idx];

  // Each entry takes its own value, its left or its right neighbour, or the new slot.
  always_ff @(posedge clk) begin
    for (int e = 0; e < NUM_TIMERS; e++) begin
      unique case (cmd.op)
        ptq_pkg::ORD_INSERT: begin
          if (IW'(e) == pos) begin
            ord[e] <= wr_slot;
          end else if (e > 0 && IW'(e) > pos) begin
            ord[e] <= ord[(e > 0) ? e - 1 : 0];
          end
        end
        ptq_pkg::ORD_DELETE: begin
          if (e < NUM_TIMERS - 1 && IW'(e) >= pos) begin
            ord[e] <= ord[(e < NUM_TIMERS - 1) ? e + 1 : e];
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

[src/periodic_timer_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// Deadline-ordered queue of periodic timers, handled one item at a time by a
// sequencer around a timer RAM with one write port and one registered read
// port. The block takes no item until every result of the previous one is
// delivered. A register searches the slots for a free one, then walks the
// order list, reading each entry, forming its deadline and comparing it,
// then links the timer and presents the result. A remove searches the order
// list entry by entry, then reads the timer. An update checks the timers in
// order until one is not due, all were checked or RESULT_CAP have fired. For
// each fired timer it then pops and rewrites it and walks the order list to
// reinsert it, and each fired result waits for the receiver. Throughput is
// set by the one RAM read port and the serial walk of the order list.
module periodic_timer_queue #(
  parameter int NUM_TIMERS = ptq_pkg::NUM_TIMERS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // now[31:0], period[62:32], tag[94:63], slot[98:95], zeros above
  input  wire logic [103:0] s_tdata,
  // kind[1:0]
  input  wire logic [1:0]   s_tuser,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // handle[3:0], fired_period[34:4], fired_tag[66:35], zeros above
  output logic      [71:0]  m_tdata,
  // event_res[1:0]
  output logic      [1:0]   m_tuser,
  output logic              m_tlast
);

  localparam int IW = $clog2(NUM_TIMERS);
  localparam int CW = $clog2(NUM_TIMERS + 1);
  localparam int PW = ptq_pkg::PERIOD_W;

  ptq_pkg::state_t st, st_next;

  // Latched item.
  ptq_pkg::kind_t k_kind;
  logic [31:0]   k_now;
  logic [PW-1:0] k_period;
  logic [31:0]   k_tag;
  logic [3:0]    k_slot;

  logic [IW-1:0]   cur;
  logic [CW-1:0]   j, n, f;
  logic [31:0]     dl, edl;
  logic [NUM_TIMERS-1:0] busy;

  // Result register.
  ptq_pkg::event_t o_ev;
  logic [3:0]    o_handle;
  logic [PW-1:0] o_period;
  logic [31:0]   o_tag;
  logic          o_last;

  // RAM and order list connections.
  logic                      ram_we;
  logic [IW-1:0]             ram_waddr, ram_raddr;
  logic [ptq_pkg::ENTRY_W-1:0] ram_wdata, ram_rdata;
  logic [31:0]   rd_start, rd_tag;
  logic [PW-1:0] rd_period;
  ptq_pkg::ord_cmd_t ocmd;
  logic [IW-1:0] ord_idx, ord_slot;

  logic        acc;
  logic [31:0] diff, elapsed;
  logic        slot_ok;

  assign acc      = s_tvalid && s_tready;
  assign s_tready = (st == ptq_pkg::S_IDLE);
  assign m_tvalid = (st == ptq_pkg::S_EMIT);
  assign m_tdata  = {5'd0, o_tag, o_period, o_handle};
  assign m_tuser  = o_ev;
  assign m_tlast  = o_last;

  assign {rd_start, rd_tag, rd_period} = ram_rdata;
  assign diff    = edl - dl;
  assign elapsed = k_now - rd_start;
  assign slot_ok = (32'(s_tdata[98:95]) < NUM_TIMERS);

  ptq_ram #(
    .WIDTH(ptq_pkg::ENTRY_W),
    .DEPTH(NUM_TIMERS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  ptq_order #(
    .NUM_TIMERS(NUM_TIMERS)
  ) u_order (
    .clk    (clk),
    .cmd    (ocmd),
    .wr_slot(cur),
    .rd_idx (ord_idx),
    .rd_slot(ord_slot)
  );

  // Order list read index follows the step being worked on.
  always_comb begin
    if (st == ptq_pkg::S_UP_RD) begin
      ord_idx = f[IW-1:0];
    end else if (st == ptq_pkg::S_UP_POP) begin
      ord_idx = '0;
    end else begin
      ord_idx = j[IW-1:0];
    end
  end

  // Next state, RAM and order list control.
  always_comb begin
    st_next   = st;
    ram_we    = 1'b0;
    ram_waddr = cur;
    ram_wdata = {k_now, rd_tag, rd_period};
    ram_raddr = ord_slot;
    ocmd.op   = ptq_pkg::ORD_NOP;
    ocmd.pos  = ptq_pkg::ORD_PW'(j);
    unique case (st)
      ptq_pkg::S_IDLE: begin
        if (acc) begin
          unique case (ptq_pkg::kind_t'(s_tuser))
            ptq_pkg::KIND_UPDATE:   st_next = ptq_pkg::S_UP_RD;
            ptq_pkg::KIND_REGISTER: begin
              st_next = (32'(n) == NUM_TIMERS) ? ptq_pkg::S_EMIT : ptq_pkg::S_FREE;
            end
            ptq_pkg::KIND_REMOVE: begin
              if (slot_ok && busy[IW'(s_tdata[98:95])]) begin
                st_next = ptq_pkg::S_RM_FIND;
              end else begin
                st_next = ptq_pkg::S_EMIT;
              end
            end
            ptq_pkg::KIND_BAD:      st_next = ptq_pkg::S_EMIT;
          endcase
        end
      end
      ptq_pkg::S_FREE: begin
        if (!busy[j[IW-1:0]]) begin
          ram_we    = 1'b1;
          ram_waddr = j[IW-1:0];
          ram_wdata = {k_now, k_tag, k_period};
          st_next   = ptq_pkg::S_LINK_RD;
        end
      end
      ptq_pkg::S_LINK_RD: begin
        st_next = (j == n) ? ptq_pkg::S_LINK_INS : ptq_pkg::S_LINK_DL;
      end
      ptq_pkg::S_LINK_DL:  st_next = ptq_pkg::S_LINK_CMP;
      ptq_pkg::S_LINK_CMP: begin
        if (diff != 32'd0 && !diff[31]) begin
          st_next = ptq_pkg::S_LINK_INS;
        end else begin
          st_next = ptq_pkg::S_LINK_RD;
        end
      end
      ptq_pkg::S_LINK_INS: begin
        ocmd.op = ptq_pkg::ORD_INSERT;
        st_next = ptq_pkg::S_EMIT;
      end
      ptq_pkg::S_RM_FIND: begin
        ram_raddr = cur;
        if (ord_slot == cur) begin
          ocmd.op = ptq_pkg::ORD_DELETE;
          st_next = ptq_pkg::S_RM_RD;
        end
      end
      ptq_pkg::S_RM_RD: st_next = ptq_pkg::S_EMIT;
      ptq_pkg::S_UP_RD: begin
        if (f == n || 32'(f) == ptq_pkg::RESULT_CAP) begin
          st_next = (f == '0) ? ptq_pkg::S_IDLE : ptq_pkg::S_UP_POP;
        end else begin
          st_next = ptq_pkg::S_UP_CHK;
        end
      end
      ptq_pkg::S_UP_CHK: begin
        if (elapsed < {1'b0, rd_period}) begin
          st_next = (f == '0) ? ptq_pkg::S_IDLE : ptq_pkg::S_UP_POP;
        end else begin
          st_next = ptq_pkg::S_UP_RD;
        end
      end
      ptq_pkg::S_UP_POP: begin
        ocmd.op  = ptq_pkg::ORD_DELETE;
        ocmd.pos = '0;
        st_next  = ptq_pkg::S_UP_WR;
      end
      ptq_pkg::S_UP_WR: begin
        ram_we  = 1'b1;
        st_next = ptq_pkg::S_LINK_RD;
      end
      ptq_pkg::S_EMIT: begin
        if (m_tready) begin
          if (k_kind == ptq_pkg::KIND_UPDATE && f != '0) begin
            st_next = ptq_pkg::S_UP_POP;
          end else begin
            st_next = ptq_pkg::S_IDLE;
          end
        end
      end
      default: st_next = ptq_pkg::S_IDLE;
    endcase
  end

  // State register and control counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= ptq_pkg::S_IDLE;
      n    <= '0;
      busy <= '0;
    end else begin
      st <= st_next;
      if (st == ptq_pkg::S_LINK_INS) begin
        n <= n + CW'(1);
      end
      if (st == ptq_pkg::S_UP_POP) begin
        n <= n - CW'(1);
      end
      if (st == ptq_pkg::S_RM_FIND && ord_slot == cur) begin
        n         <= n - CW'(1);
        busy[cur] <= 1'b0;
      end
      if (st == ptq_pkg::S_FREE && !busy[j[IW-1:0]]) begin
        busy[j[IW-1:0]] <= 1'b1;
      end
    end
  end

  // Item fields, walk pointers, deadlines and the result register.
  always_ff @(posedge clk) begin
    unique case (st)
      ptq_pkg::S_IDLE: begin
        k_kind   <= ptq_pkg::kind_t'(s_tuser);
        k_now    <= s_tdata[31:0];
        k_period <= s_tdata[62:32];
        k_tag    <= s_tdata[94:63];
        k_slot   <= s_tdata[98:95];
        cur      <= IW'(s_tdata[98:95]);
        j        <= '0;
        f        <= '0;
        o_ev     <= ptq_pkg::EV_REJECTED;
        o_handle <= '0;
        o_period <= '0;
        o_tag    <= '0;
        o_last   <= 1'b1;
        if (ptq_pkg::kind_t'(s_tuser) == ptq_pkg::KIND_REMOVE) begin
          o_handle <= s_tdata[98:95];
        end
      end
      ptq_pkg::S_FREE: begin
        if (!busy[j[IW-1:0]]) begin
          cur      <= j[IW-1:0];
          dl       <= k_now + {1'b0, k_period};
          j        <= '0;
          o_ev     <= ptq_pkg::EV_REGISTERED;
          o_handle <= 4'(j);
          o_period <= k_period;
          o_tag    <= k_tag;
        end else begin
          j <= j + CW'(1);
        end
      end
      ptq_pkg::S_LINK_DL: edl <= rd_start + {1'b0, rd_period};
      ptq_pkg::S_LINK_CMP: begin
        if (!(diff != 32'd0 && !diff[31])) begin
          j <= j + CW'(1);
        end
      end
      ptq_pkg::S_RM_FIND: begin
        if (ord_slot != cur) begin
          j <= j + CW'(1);
        end
      end
      ptq_pkg::S_RM_RD: begin
        o_ev     <= ptq_pkg::EV_REMOVED;
        o_handle <= k_slot;
        o_period <= rd_period;
        o_tag    <= rd_tag;
      end
      ptq_pkg::S_UP_CHK: begin
        if (!(elapsed < {1'b0, rd_period})) begin
          f <= f + CW'(1);
        end
      end
      ptq_pkg::S_UP_POP: begin
        cur <= ord_slot;
        f   <= f - CW'(1);
      end
      ptq_pkg::S_UP_WR: begin
        dl       <= k_now + {1'b0, rd_period};
        j        <= f;
        o_ev     <= ptq_pkg::EV_FIRED;
        o_handle <= 4'(cur);
        o_period <= rd_period;
        o_tag    <= rd_tag;
        o_last   <= (f == '0);
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

[verif/periodic_timer_queue_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// Watches both streams of the timer queue. It keeps its own deadline-ordered
// copy of the timer table, works out the results of every accepted input
// item and compares each delivered result item with the oldest one expected.
module periodic_timer_queue_checker (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  input  wire logic         s_tready,
  // now[31:0], period[62:32], tag[94:63], slot[98:95], zeros above
  input  wire logic [103:0] s_tdata,
  // kind[1:0]
  input  wire logic [1:0]   s_tuser,
  input  wire logic         m_tvalid,
  input  wire logic         m_tready,
  // handle[3:0], fired_period[34:4], fired_tag[66:35], zeros above
  input  wire logic [71:0]  m_tdata,
  // event_res[1:0]
  input  wire logic [1:0]   m_tuser,
  input  wire logic         m_tlast,
  input  wire logic         drain,
  output int                errors,
  output int                pending,
  output int                fired_seen
);

  localparam int NT = 16;

  typedef struct {
    ptq_pkg::event_t ev;
    logic [3:0]  handle;
    logic [30:0] period;
    logic [31:0] tag;
    logic        last;
  } timer_event_t;

  // Local copy of the timer table and its deadline order.
  logic        busy [NT];
  logic [30:0] per  [NT];
  logic [31:0] tg   [NT];
  logic [31:0] strt [NT];
  logic [3:0]  order [NT];
  int          live;

  timer_event_t due_events [$];
  logic         drain_seen;

  initial begin
    errors = 0;
    fired_seen = 0;
    drain_seen = 1'b0;
  end

  assign pending = due_events.size();

  task automatic report(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    errors++;
  endtask

  function automatic void queue_event(ptq_pkg::event_t ev, logic [3:0] h,
                                      logic [30:0] p, logic [31:0] t, logic l);
    timer_event_t e;
    e.ev = ev; e.handle = h; e.period = p; e.tag = t; e.last = l;
    due_events = {due_events, e};
  endfunction

  // Put a busy slot behind every entry whose deadline is not later than its own.
  function automatic void link_timer(logic [3:0] s);
    logic [31:0] dl;
    logic [31:0] diff;
    int          pos;
    dl = strt[s] + {1'b0, per[s]};
    pos = live;
    if (live >= NT) return;
    for (int i = 0; i < live; i++) begin
      diff = (strt[order[i]] + {1'b0, per[order[i]]}) - dl;
      if (diff != 0 && !diff[31]) begin
        pos = i;
        break;
      end
    end
    for (int i = live; i > pos; i--) order[i] = order[i-1];
    order[pos] = s;
    live++;
  endfunction

  function automatic void predict_events(ptq_pkg::kind_t kind, logic [31:0] now,
                                         logic [30:0] p, logic [31:0] t,
                                         logic [3:0] slot);
    logic [3:0] fired [NT];
    int         k;
    int         s;
    int         pos;
    case (kind)
      ptq_pkg::KIND_UPDATE: begin
        k = 0;
        while (k < live && k < ptq_pkg::RESULT_CAP) begin
          if ((now - strt[order[k]]) < {1'b0, per[order[k]]}) break;
          fired[k] = order[k];
          k++;
        end
        if (k > 0) begin
          for (int i = 0; i < live - k; i++) order[i] = order[i+k];
          live -= k;
          for (int i = 0; i < k; i++) begin
            queue_event(ptq_pkg::EV_FIRED, fired[i], per[fired[i]], tg[fired[i]],
                        i == k - 1);
            strt[fired[i]] = now;
            link_timer(fired[i]);
          end
        end
      end
      ptq_pkg::KIND_REGISTER: begin
        s = NT;
        for (int i = 0; i < NT; i++) begin
          if (!busy[i]) begin
            s = i;
            break;
          end
        end
        if (s >= NT || live >= NT) begin
          queue_event(ptq_pkg::EV_REJECTED, 4'd0, 31'd0, 32'd0, 1'b1);
        end else begin
          busy[s] = 1'b1;
          per[s] = p;
          tg[s] = t;
          strt[s] = now;
          link_timer(s[3:0]);
          queue_event(ptq_pkg::EV_REGISTERED, s[3:0], p, t, 1'b1);
        end
      end
      ptq_pkg::KIND_REMOVE: begin
        if (!busy[slot]) begin
          queue_event(ptq_pkg::EV_REJECTED, slot, 31'd0, 32'd0, 1'b1);
        end else begin
          pos = -1;
          for (int i = 0; i < live; i++) begin
            if (order[i] == slot) begin
              pos = i;
              break;
            end
          end
          if (pos >= 0) begin
            for (int i = pos; i < live - 1; i++) order[i] = order[i+1];
            live--;
          end
          busy[slot] = 1'b0;
          queue_event(ptq_pkg::EV_REMOVED, slot, per[slot], tg[slot], 1'b1);
        end
      end
      default: queue_event(ptq_pkg::EV_REJECTED, 4'd0, 31'd0, 32'd0, 1'b1);
    endcase
  endfunction

  // Predict on every accepted input item, compare every accepted result item.
  always @(posedge clk) begin
    timer_event_t e;
    if (rst) begin
      for (int i = 0; i < NT; i++) begin
        busy[i] = 1'b0; per[i] = '0; tg[i] = '0; strt[i] = '0; order[i] = '0;
      end
      live = 0;
    end else begin
      if (s_tvalid && s_tready)
        predict_events(ptq_pkg::kind_t'(s_tuser), s_tdata[31:0], s_tdata[62:32],
                       s_tdata[94:63], s_tdata[98:95]);
      if (m_tvalid && m_tready) begin
        if (m_tuser == ptq_pkg::EV_FIRED) fired_seen++;
        if (due_events.size() == 0) begin
          report($sformatf("result item with nothing expected, event %0d", m_tuser));
        end else begin
          e = due_events.pop_front();
          if (m_tuser != e.ev)
            report($sformatf("event %0d, expected %0d", m_tuser, e.ev));
          if (m_tdata[3:0] != e.handle)
            report($sformatf("handle %0d, expected %0d", m_tdata[3:0], e.handle));
          if (m_tdata[34:4] != e.period)
            report($sformatf("period %h, expected %h", m_tdata[34:4], e.period));
          if (m_tdata[66:35] != e.tag)
            report($sformatf("tag %h, expected %h", m_tdata[66:35], e.tag));
          if (m_tlast != e.last)
            report($sformatf("last %0d, expected %0d", m_tlast, e.last));
        end
      end
      if (drain && !drain_seen) begin
        drain_seen = 1'b1;
        if (due_events.size() != 0)
          report($sformatf("%0d result items never arrived", due_events.size()));
      end
    end
  end

endmodule
`default_nettype wire

[verif/periodic_timer_queue_test.sv]
`timescale 1ns / 1ps
`default_nettype none
module periodic_timer_queue_test;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int RANDOM_ITEMS = 360;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [103:0] s_tdata = '0;
  logic [1:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [71:0]  m_tdata;
  logic [1:0]   m_tuser;
  logic         m_tlast;
  logic         drain = 1'b0;

  int errors;
  int pending;
  int fired_seen;
  int cycles = 0;
  int kind_count [4] = '{0, 0, 0, 0};
  int results_taken = 0;
  logic [31:0] clock_ms;

  periodic_timer_queue uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  periodic_timer_queue_checker checker_i (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast), .drain(drain),
    .errors(errors), .pending(pending), .fired_seen(fired_seen)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("periodic_timer_queue_test: FAIL");
      $finish;
    end
  end

  // Offer one input item after a random gap and hold it until it is taken.
  task automatic send_item(ptq_pkg::kind_t kind, logic [31:0] now, logic [30:0] p,
                           logic [31:0] t, logic [3:0] slot);
    int gap;
    gap = $urandom_range(0, 6);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {5'd0, slot, t, p, now};
    kind_count[kind]++;
    do @(posedge clk); while (!(s_tvalid && s_tready));
  endtask

  // Receiver: random stall per result item, one long hold-off early on.
  initial begin
    int stall;
    @(negedge rst);
    forever begin
      if (results_taken == 20) begin
        m_tready <= 1'b0;
        repeat (400) @(posedge clk);
      end
      stall = $urandom_range(0, 6);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
      results_taken++;
    end
  end

  // Stimulus and verdict.
  initial begin
    int roll;
    logic [30:0] p;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    clock_ms = 32'hFFFF_F000;

    // Directed: undefined kind, idle removal, period extremes, full table,
    // an update firing every timer, and a double removal.
    send_item(ptq_pkg::KIND_BAD, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 4'hF);
    send_item(ptq_pkg::KIND_REMOVE, clock_ms, 31'd0, 32'd0, 4'd15);
    send_item(ptq_pkg::KIND_REGISTER, clock_ms, 31'd0, 32'hFFFF_FFFF, 4'd0);
    send_item(ptq_pkg::KIND_REGISTER, clock_ms, 31'h7FFF_FFFF, 32'd0, 4'd0);
    send_item(ptq_pkg::KIND_UPDATE, clock_ms, 31'd0, 32'd0, 4'd0);
    for (int i = 0; i < 14; i++)
      send_item(ptq_pkg::KIND_REGISTER, clock_ms + i, 31'($urandom_range(0, 100)),
                $urandom, 4'd0);
    send_item(ptq_pkg::KIND_REGISTER, clock_ms, 31'd5, 32'h1234_5678, 4'd0);
    clock_ms = clock_ms + 32'h7FFF_FFFF;
    send_item(ptq_pkg::KIND_UPDATE, clock_ms, 31'd0, 32'd0, 4'd0);
    send_item(ptq_pkg::KIND_REMOVE, clock_ms, 31'd0, 32'd0, 4'd0);
    send_item(ptq_pkg::KIND_REMOVE, clock_ms, 31'd0, 32'd0, 4'd0);

    // Random: mostly registrations and updates on a clock that creeps
    // forward, with removals, odd jumps in time and undefined kinds.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      roll = $urandom_range(0, 99);
      if ($urandom_range(0, 15) == 0) p = 31'($urandom);
      else p = 31'($urandom_range(0, 150));
      if (roll < 40) begin
        send_item(ptq_pkg::KIND_REGISTER, clock_ms, p, $urandom, 4'($urandom));
      end else if (roll < 75) begin
        if ($urandom_range(0, 19) == 0) clock_ms = $urandom;
        else clock_ms = clock_ms + $urandom_range(0, 60);
        send_item(ptq_pkg::KIND_UPDATE, clock_ms, p, $urandom, 4'($urandom));
      end else if (roll < 95) begin
        send_item(ptq_pkg::KIND_REMOVE, clock_ms, p, $urandom, 4'($urandom));
      end else begin
        send_item(ptq_pkg::KIND_BAD, $urandom, p, $urandom, 4'($urandom));
      end
    end
    s_tvalid <= 1'b0;

    // Let the last results out, then allow for an update still walking.
    while (pending != 0) @(posedge clk);
    repeat (1500) @(posedge clk);
    drain <= 1'b1;
    repeat (2) @(posedge clk);

    $display("sent %0d updates, %0d registrations, %0d removals, %0d undefined items",
             kind_count[ptq_pkg::KIND_UPDATE], kind_count[ptq_pkg::KIND_REGISTER],
             kind_count[ptq_pkg::KIND_REMOVE], kind_count[ptq_pkg::KIND_BAD]);
    $display("timers fired: %0d, result items checked: %0d", fired_seen, results_taken);
    if (errors == 0)
      $display("periodic_timer_queue_test: PASS");
    else
      $display("periodic_timer_queue_test: FAIL");
    $finish;
  end

endmodule
`default_nettype wire
